/* rtl/load_delay_dependency_check_defines.svh */
// assertion macros for the load delay dependency check checker
// no dependencies; taken in by include where assertions are written
`ifndef LOAD_DELAY_DEPENDENCY_CHECK_DEFINES_SVH
`define LOAD_DELAY_DEPENDENCY_CHECK_DEFINES_SVH

// general form with explicit clock and active-low reset
`define LDDC_ASSERT_CLKRST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// house clock and reset
`define LDDC_ASSERT(label, prop, msg) \
    `LDDC_ASSERT_CLKRST(label, i_clk, i_rst_n, prop, msg)

`endif

/* rtl/lddc_pkg.sv */
// types, codes and decode tables for the load delay dependency check
// no dependencies; imported by the stage, classify and checker modules
package lddc_pkg;

    typedef enum logic [1:0] {
        CLS_NONE = 2'd0,
        CLS_RS   = 2'd1,
        CLS_RT   = 2'd2,
        CLS_BOTH = 2'd3
    } t_src_class;

    typedef enum logic [1:0] {
        DEP_NONE   = 2'd0,
        DEP_INSIDE = 2'd1,
        DEP_ACROSS = 2'd2
    } t_dep;

    typedef struct packed {
        logic [31:0] next_instruction;
        logic [4:0]  load_target;
        logic        block_ending;
    } t_req;

    typedef struct packed {
        logic valid;
        t_req req;
    } t_stage;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_COP0    = 6'h10;
    localparam logic [5:0] OP_COP2    = 6'h12;
    localparam logic [4:0] RS_MT      = 5'd4;
    localparam logic [4:0] RS_CT      = 5'd6;
    localparam logic [5:0] FN_ZERO    = 6'd0;
    localparam logic [4:0] REG_ZERO   = 5'd0;

    function automatic t_src_class opcode_class(input logic [5:0] op);
        t_src_class cls;
        case (op)
            6'd1, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14:
                cls = CLS_RS;
            6'd4, 6'd5:
                cls = CLS_BOTH;
            6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38:
                cls = CLS_RS;
            6'd40, 6'd41, 6'd42, 6'd43, 6'd46:
                cls = CLS_RS;
            6'd48, 6'd49, 6'd50, 6'd51, 6'd56, 6'd57, 6'd58, 6'd59:
                cls = CLS_RS;
            default:
                cls = CLS_NONE;
        endcase
        return cls;
    endfunction

    function automatic t_src_class function_class(input logic [5:0] fn);
        t_src_class cls;
        case (fn)
            6'd0, 6'd4, 6'd6, 6'd7:
                cls = CLS_BOTH;
            6'd2, 6'd3:
                cls = CLS_RT;
            6'd17, 6'd19:
                cls = CLS_RS;
            6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd42, 6'd43:
                cls = CLS_BOTH;
            default:
                cls = CLS_NONE;
        endcase
        return cls;
    endfunction

endpackage

/* rtl/lddc_req_if.sv */
// request channel: instruction word after a load, load target, block end flag
// no dependencies
interface lddc_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] next_instruction;
    logic [4:0]  load_target;
    logic        block_ending;

    modport source (output valid, output next_instruction, output load_target,
                    output block_ending, input ready);
    modport sink (input valid, input next_instruction, input load_target,
                  input block_ending, output ready);
endinterface

/* rtl/lddc_rsp_if.sv */
// result channel: dependency code
// no dependencies
interface lddc_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] dependency;

    modport source (output valid, output dependency, input ready);
    modport sink (input valid, input dependency, output ready);
endinterface

/* rtl/lddc_in_stage.sv */
// input register stage of the load delay dependency check
// depends on lddc_pkg and lddc_req_if
module lddc_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lddc_req_if.sink      i_req,
    input  logic          i_advance,
    output lddc_pkg::t_stage o_stage
);
    import lddc_pkg::*;

    logic r_valid;
    t_req r_req;
    logic n_valid;
    logic w_take;

    assign w_take      = !r_valid || i_advance;
    assign i_req.ready = w_take;
    assign n_valid     = w_take ? i_req.valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_req.valid) begin
            r_req.next_instruction <= i_req.next_instruction;
            r_req.load_target      <= i_req.load_target;
            r_req.block_ending     <= i_req.block_ending;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.req   = r_req;
endmodule

/* rtl/lddc_classify.sv */
// combinational decode of one request into a dependency code
// depends on lddc_pkg
module lddc_classify (
    input  lddc_pkg::t_req i_req,
    output lddc_pkg::t_dep o_dep
);
    import lddc_pkg::*;

    logic [5:0] w_op;
    logic [4:0] w_rs;
    logic [4:0] w_rt;
    logic [5:0] w_fn;
    t_src_class w_cls;
    logic       w_rs_eq;
    logic       w_rt_eq;
    logic       w_hit;

    assign w_op    = i_req.next_instruction[31:26];
    assign w_rs    = i_req.next_instruction[25:21];
    assign w_rt    = i_req.next_instruction[20:16];
    assign w_fn    = i_req.next_instruction[5:0];
    assign w_rs_eq = (w_rs == i_req.load_target);
    assign w_rt_eq = (w_rt == i_req.load_target);
    assign w_cls   = (w_op == OP_SPECIAL) ? function_class(w_fn) : opcode_class(w_op);
    assign w_hit   = (w_cls[0] && w_rs_eq) || (w_cls[1] && w_rt_eq);

    always_comb begin
        if (i_req.block_ending && (i_req.load_target != REG_ZERO)) begin
            o_dep = DEP_ACROSS;
        end else if (i_req.load_target == REG_ZERO) begin
            o_dep = DEP_NONE;
        end else if (w_op == OP_COP0) begin
            o_dep = ((w_rs == RS_MT) && w_rt_eq) ? DEP_INSIDE : DEP_NONE;
        end else if (w_op == OP_COP2) begin
            o_dep = ((w_fn == FN_ZERO) && ((w_rs == RS_MT) || (w_rs == RS_CT)) && w_rt_eq)
                    ? DEP_INSIDE : DEP_NONE;
        end else begin
            o_dep = w_hit ? DEP_INSIDE : DEP_NONE;
        end
    end
endmodule

/* rtl/lddc_out_stage.sv */
// result register stage of the load delay dependency check
// depends on lddc_pkg and lddc_rsp_if
module lddc_out_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  lddc_pkg::t_dep i_dep,
    output logic           o_take,
    lddc_rsp_if.source     o_rsp
);
    import lddc_pkg::*;

    logic r_valid;
    t_dep r_dep;
    logic n_valid;

    assign o_take  = !r_valid || o_rsp.ready;
    assign n_valid = o_take ? i_valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_dep <= i_dep;
        end
    end

    assign o_rsp.valid      = r_valid;
    assign o_rsp.dependency = r_dep;
endmodule

/* rtl/load_delay_dependency_check.sv */
// Load delay dependency check: for each request (the instruction word after a
// load, the load's target register and a block end flag) one result gives 0 for
// no dependency, 1 for a dependency inside the block, 2 for one across blocks.
// A request is taken every cycle while results are taken; its result is held in the
// input register, decoded combinationally and registered in the result register,
// which holds it on the output until it is taken.
// Input ready follows output ready combinationally through both registers.
// depends on lddc_pkg, lddc_req_if, lddc_rsp_if, the stage modules and lddc_classify
module load_delay_dependency_check (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lddc_req_if.sink   i_req,
    lddc_rsp_if.source o_rsp
);
    import lddc_pkg::*;

    t_stage w_stage;
    t_dep   w_dep;
    logic   w_take;

    lddc_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .i_advance (w_take),
        .o_stage   (w_stage)
    );

    lddc_classify u_classify (
        .i_req (w_stage.req),
        .o_dep (w_dep)
    );

    lddc_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_stage.valid),
        .i_dep   (w_dep),
        .o_take  (w_take),
        .o_rsp   (o_rsp)
    );
endmodule

/* rtl/lddc_checker.sv */
// port-level checks on the load delay dependency check, bound to the top level
// depends on lddc_pkg and load_delay_dependency_check_defines.svh
`include "load_delay_dependency_check_defines.svh"

module lddc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_valid,
    input logic       i_req_ready,
    input logic [4:0] i_load_target,
    input logic       i_block_ending,
    input logic       i_rsp_valid,
    input logic       i_rsp_ready,
    input logic [1:0] i_dependency
);
    import lddc_pkg::*;

    logic w_req_acc;
    logic w_across;

    assign w_req_acc = i_req_valid && i_req_ready;
    assign w_across  = w_req_acc && i_block_ending && (i_load_target != REG_ZERO);

    // stalled result holds
    `LDDC_ASSERT(a_rsp_hold, i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_dependency), "result changed while stalled")
    // empty output means room for a request
    `LDDC_ASSERT(a_ready_when_empty, !i_rsp_valid |-> i_req_ready, "request refused with empty output")
    // an accepted request's result reaches the output when the output drains
    `LDDC_ASSERT(a_latency, w_req_acc ##1 i_rsp_ready |=> i_rsp_valid, "result missing after two cycles")
    // block end with nonzero target gives across-block code
    `LDDC_ASSERT(a_across, w_across ##1 i_rsp_ready |=> i_dependency == DEP_ACROSS, "block end code wrong")
endmodule

bind load_delay_dependency_check lddc_checker u_lddc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_load_target  (i_req.load_target),
    .i_block_ending (i_req.block_ending),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_dependency   (o_rsp.dependency)
);

/* sim/tb_load_delay_dependency_check.sv */
// testbench for load_delay_dependency_check: directed and random requests checked
// against a local dependency predictor; depends on lddc_pkg, lddc_req_if, lddc_rsp_if
module tb_load_delay_dependency_check;
    timeunit 1ns;
    timeprecision 1ps;

    import lddc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned PRINT_LIMIT = 200;

    localparam logic [5:0] OP_J       = 6'd2;
    localparam logic [5:0] OP_BEQ     = 6'd4;
    localparam logic [5:0] OP_LUI     = 6'd15;
    localparam logic [5:0] OP_LWL     = 6'd34;
    localparam logic [5:0] OP_LW      = 6'd35;
    localparam logic [5:0] OP_SWR     = 6'd46;
    localparam logic [5:0] OP_LWC2    = 6'd50;
    localparam logic [5:0] FN_SLL     = 6'd0;
    localparam logic [5:0] FN_SRL     = 6'd2;
    localparam logic [5:0] FN_SYSCALL = 6'd12;
    localparam logic [5:0] FN_MTHI    = 6'd17;
    localparam logic [5:0] FN_ADD     = 6'd32;
    localparam logic [5:0] FN_ONE     = 6'd1;
    localparam logic [4:0] RS_MF      = 5'd0;
    localparam logic [4:0] RS_MT2     = 5'd5;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lddc_req_if req_if ();
    lddc_rsp_if rsp_if ();

    load_delay_dependency_check DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #4 i_clk = ~i_clk;

    t_dep        expected_deps[$];
    t_dep        oldest_dep;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned stall_left = 0;
    bit          steady_flow = 1'b0;

    function automatic t_src_class main_class(input logic [5:0] op);
        case (op)
            6'd4, 6'd5:
                return CLS_BOTH;
            6'd1, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14,
            6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38,
            6'd40, 6'd41, 6'd42, 6'd43, 6'd46,
            6'd48, 6'd49, 6'd50, 6'd51, 6'd56, 6'd57, 6'd58, 6'd59:
                return CLS_RS;
            default:
                return CLS_NONE;
        endcase
    endfunction

    function automatic t_src_class special_class(input logic [5:0] fn);
        case (fn)
            6'd0, 6'd4, 6'd6, 6'd7, 6'd42, 6'd43,
            6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39:
                return CLS_BOTH;
            6'd2, 6'd3:
                return CLS_RT;
            6'd17, 6'd19:
                return CLS_RS;
            default:
                return CLS_NONE;
        endcase
    endfunction

    function automatic t_dep predict_dependency(input logic [31:0] word,
                                                input logic [4:0] tgt,
                                                input logic ending);
        logic [5:0] op;
        logic [5:0] fn;
        logic [4:0] rs;
        logic [4:0] rt;
        t_src_class cls;
        logic       hit;
        op = word[31:26];
        rs = word[25:21];
        rt = word[20:16];
        fn = word[5:0];
        if (ending && tgt != REG_ZERO)
            return DEP_ACROSS;
        if (tgt == REG_ZERO)
            return DEP_NONE;
        if (op == OP_COP0)
            return (rs == RS_MT && rt == tgt) ? DEP_INSIDE : DEP_NONE;
        if (op == OP_COP2)
            return (fn == FN_ZERO && (rs == RS_MT || rs == RS_CT) && rt == tgt)
                   ? DEP_INSIDE : DEP_NONE;
        cls = (op == OP_SPECIAL) ? special_class(fn) : main_class(op);
        hit = ((cls == CLS_RS || cls == CLS_BOTH) && rs == tgt) ||
              ((cls == CLS_RT || cls == CLS_BOTH) && rt == tgt);
        return hit ? DEP_INSIDE : DEP_NONE;
    endfunction

    function automatic logic [31:0] build_word(input logic [5:0] op, input logic [4:0] rs,
                                               input logic [4:0] rt, input logic [15:0] low);
        return {op, rs, rt, low};
    endfunction

    // mostly short, a few long
    function automatic int unsigned pick_idle();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    task automatic hold_off(input int unsigned cycles);
        req_if.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic send_request(input logic [31:0] word, input logic [4:0] tgt,
                                input logic ending);
        int unsigned gap;
        gap = steady_flow ? 0 : pick_idle();
        if (gap != 0)
            hold_off(gap);
        req_if.valid            <= 1'b1;
        req_if.next_instruction <= word;
        req_if.load_target      <= tgt;
        req_if.block_ending     <= ending;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        expected_deps.push_back(predict_dependency(word, tgt, ending));
    endtask

    task automatic wait_for_drain();
        req_if.valid <= 1'b0;
        while (expected_deps.size() != 0) @(posedge i_clk);
    endtask

    // well-formed requests mostly: sources aimed at the target, coprocessor moves
    task automatic random_request();
        logic [5:0]  op;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  tgt;
        logic [15:0] low;
        logic        ending;
        int unsigned pick;
        tgt    = ($urandom_range(0, 9) == 0) ? REG_ZERO : 5'($urandom_range(1, 31));
        ending = ($urandom_range(0, 11) == 0);
        if ($urandom_range(0, 6) == 0) begin
            send_request($urandom, 5'($urandom), 1'($urandom));
            return;
        end
        pick = $urandom_range(0, 9);
        if (pick < 3)
            op = OP_SPECIAL;
        else if (pick == 3)
            op = OP_COP0;
        else if (pick == 4)
            op = OP_COP2;
        else
            op = 6'($urandom);
        rs  = ($urandom_range(0, 4) < 2) ? tgt : 5'($urandom);
        rt  = ($urandom_range(0, 4) < 2) ? tgt : 5'($urandom);
        low = 16'($urandom);
        if (op == OP_COP0 && $urandom_range(0, 1) == 1)
            rs = RS_MT;
        if (op == OP_COP2) begin
            if ($urandom_range(0, 2) != 0)
                rs = $urandom_range(0, 1) ? RS_MT : RS_CT;
            if ($urandom_range(0, 1) == 1)
                low[5:0] = FN_ZERO;
        end
        send_request(build_word(op, rs, rt, low), tgt, ending);
    endtask

    task automatic test_directed();
        send_request(32'h0000_0000, REG_ZERO, 1'b0);
        send_request(32'hFFFF_FFFF, 5'd31, 1'b1);
        send_request(32'hFFFF_FFFF, REG_ZERO, 1'b1);
        send_request(build_word(OP_SPECIAL, 5'd5, 5'd9, {10'h155, FN_ADD}), 5'd5, 1'b0);
        send_request(build_word(OP_SPECIAL, 5'd0, 5'd7, {10'h0, FN_SLL}), 5'd7, 1'b0);
        send_request(build_word(OP_SPECIAL, 5'd3, 5'd8, {10'h2AA, FN_SRL}), 5'd3, 1'b0);
        send_request(build_word(OP_SPECIAL, 5'd12, 5'd0, {10'h0, FN_MTHI}), 5'd12, 1'b0);
        send_request(build_word(OP_SPECIAL, 5'd6, 5'd6, {10'h3FF, FN_SYSCALL}), 5'd6, 1'b0);
        send_request(build_word(OP_COP0, RS_MT, 5'd17, 16'h6000), 5'd17, 1'b0);
        send_request(build_word(OP_COP0, RS_MF, 5'd17, 16'h6000), 5'd17, 1'b0);
        send_request(build_word(OP_COP2, RS_MT, 5'd20, 16'hF800), 5'd20, 1'b0);
        send_request(build_word(OP_COP2, RS_CT, 5'd21, 16'h0000), 5'd21, 1'b0);
        send_request(build_word(OP_COP2, RS_MT, 5'd20, {10'h0, FN_ONE}), 5'd20, 1'b0);
        send_request(build_word(OP_COP2, RS_MT2, 5'd20, 16'h0000), 5'd20, 1'b0);
        send_request(build_word(OP_BEQ, 5'd1, 5'd2, 16'hFFFE), 5'd2, 1'b0);
        send_request(build_word(OP_LW, 5'd29, 5'd4, 16'h0010), 5'd29, 1'b0);
        send_request(build_word(OP_LWL, 5'd1, 5'd10, 16'h0003), 5'd10, 1'b0);
        send_request(build_word(OP_SWR, 5'd10, 5'd11, 16'h0000), 5'd10, 1'b0);
        send_request(build_word(OP_LUI, 5'd9, 5'd9, 16'h8000), 5'd9, 1'b0);
        send_request(32'hFFFF_FFFF, 5'd31, 1'b0);
        send_request(build_word(OP_LWC2, 5'd15, 5'd1, 16'h0004), 5'd15, 1'b0);
        send_request(build_word(OP_J, 5'd31, 5'd31, 16'hFFFF), 5'd31, 1'b0);
        wait_for_drain();
    endtask

    task automatic test_drain_pause();
        repeat (5) begin
            repeat (40) random_request();
            wait_for_drain();
        end
    endtask

    task automatic test_back_to_back();
        steady_flow = 1'b1;
        repeat (200) random_request();
        steady_flow = 1'b0;
    endtask

    task automatic test_random_traffic();
        repeat (1530) random_request();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (steady_flow) begin
            rsp_if.ready <= 1'b1;
        end else if (stall_left != 0) begin
            rsp_if.ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            stall_left = pick_idle();
            rsp_if.ready <= (stall_left == 0);
            if (stall_left != 0)
                stall_left = stall_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_deps.size() == 0) begin
                report_mismatch($sformatf("result %0d with no request pending",
                                          rsp_if.dependency));
            end else begin
                oldest_dep = expected_deps.pop_front();
                if (rsp_if.dependency !== oldest_dep)
                    report_mismatch($sformatf("dependency expected %0d got %0d",
                                              oldest_dep, rsp_if.dependency));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_load_delay_dependency_check failed");
            $finish;
        end
    end

    initial begin
        i_rst_n                 <= 1'b0;
        req_if.valid            <= 1'b0;
        req_if.next_instruction <= '0;
        req_if.load_target      <= '0;
        req_if.block_ending     <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_drain_pause();
        test_back_to_back();
        test_random_traffic();

        wait_for_drain();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0 && expected_deps.size() == 0) begin
            $display("tb_load_delay_dependency_check passed");
        end else begin
            $display("tb_load_delay_dependency_check failed");
        end
        $finish;
    end

endmodule
